FILE: sv/bkr_pkg.sv
// Shared types, constants and helpers for the blackbody kelvin to RGB unit.
// Holds the fixed-point coefficient tables and the rounding shift.
// No dependencies.
package bkr_pkg;

  typedef enum logic [1:0] {
    BR_LOW,
    BR_MID,
    BR_HIGH
  } ybr_t;

  typedef struct packed {
    logic [15:0] gain;
    ybr_t        yb;
  } side_t;

  typedef struct packed {
    logic [15:0] gain;
    logic        sx;
    logic        sz;
  } xside_t;

  localparam logic [15:0] T_MIN     = 16'd1000;
  localparam logic [15:0] T_MAX     = 16'd40000;
  localparam logic [15:0] T_SPLIT_X = 16'd4000;
  localparam logic [15:0] T_SPLIT_Y = 16'd2222;

  localparam logic [1:0] IX_C3 = 2'd0;
  localparam logic [1:0] IX_C2 = 2'd1;
  localparam logic [1:0] IX_C1 = 2'd2;
  localparam logic [1:0] IX_C0 = 2'd3;

  localparam longint unsigned TEN7 = 64'd10000000;
  localparam longint unsigned TEN8 = 64'd100000000;
  localparam longint unsigned TEN4 = 64'd10000;
  localparam longint unsigned TEN6 = 64'd1000000;

  localparam longint XCO [2][4] = '{
    '{-longint'((64'd266123900 + 64'd128) / 64'd256),
      -longint'(((64'd2343589 << 8) + 64'd5) / 64'd10),
      longint'(((64'd8776956 << 24) + TEN4 / 2) / TEN4),
      longint'(((64'd179910 << 24) + TEN6 / 2) / TEN6)},
    '{-longint'((64'd3025846900 + 64'd128) / 64'd256),
      longint'(((64'd21070379 << 8) + 64'd5) / 64'd10),
      longint'(((64'd2226347 << 24) + TEN4 / 2) / TEN4),
      longint'(((64'd240390 << 24) + TEN6 / 2) / TEN6)}
  };

  localparam longint YCO [3][4] = '{
    '{-longint'(((64'd11063814 << 24) + TEN7 / 2) / TEN7),
      -longint'(((64'd134811020 << 24) + TEN8 / 2) / TEN8),
      longint'(((64'd218555832 << 24) + TEN8 / 2) / TEN8),
      -longint'(((64'd20219683 << 24) + TEN8 / 2) / TEN8)},
    '{-longint'(((64'd9549476 << 24) + TEN7 / 2) / TEN7),
      -longint'(((64'd137418593 << 24) + TEN8 / 2) / TEN8),
      longint'(((64'd209137015 << 24) + TEN8 / 2) / TEN8),
      -longint'(((64'd16748867 << 24) + TEN8 / 2) / TEN8)},
    '{longint'(((64'd30817580 << 24) + TEN7 / 2) / TEN7),
      -longint'(((64'd587338670 << 24) + TEN8 / 2) / TEN8),
      longint'(((64'd375112997 << 24) + TEN8 / 2) / TEN8),
      -longint'(((64'd37001483 << 24) + TEN8 / 2) / TEN8)}
  };

  localparam longint MAT [3][3] = '{
    '{longint'(((64'd32404542 << 24) + TEN7 / 2) / TEN7),
      -longint'(((64'd15371385 << 24) + TEN7 / 2) / TEN7),
      -longint'(((64'd4985314 << 24) + TEN7 / 2) / TEN7)},
    '{-longint'(((64'd9692660 << 24) + TEN7 / 2) / TEN7),
      longint'(((64'd18760108 << 24) + TEN7 / 2) / TEN7),
      longint'(((64'd415560 << 24) + TEN7 / 2) / TEN7)},
    '{longint'(((64'd556434 << 24) + TEN7 / 2) / TEN7),
      -longint'(((64'd2040259 << 24) + TEN7 / 2) / TEN7),
      longint'(((64'd10572252 << 24) + TEN7 / 2) / TEN7)}
  };

  // Arithmetic right shift that rounds to nearest, ties away from zero.
  function automatic longint shr_round(input longint v, input int unsigned s);
    longint unsigned half;
    longint unsigned mag;
    half = 64'd1 << (s - 1);
    mag  = (v < 0) ? 64'(-v) : 64'(v);
    mag  = (mag + half) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint xcoef(input logic hi, input logic [1:0] k);
    return hi ? XCO[1][k] : XCO[0][k];
  endfunction

  function automatic longint ycoef(input ybr_t b, input logic [1:0] k);
    longint c;
    unique case (b)
      BR_LOW:  c = YCO[0][k];
      BR_MID:  c = YCO[1][k];
      default: c = YCO[2][k];
    endcase
    return c;
  endfunction

endpackage

FILE: sv/bkr_udiv.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Several lanes share one valid bit and one side-band word.
// No dependencies.
module bkr_udiv #(
  parameter int NW    = 33,
  parameter int DW    = 16,
  parameter int QW    = 23,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NW-1:0]     in_num,
  input  logic [LANES-1:0][DW-1:0]     in_den,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [LANES-1:0][QW-1:0]     out_quo,
  output logic [SW-1:0]                out_side
);

  localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic                     vld  [QW];
  logic [LANES-1:0][NW-1:0] rem  [QW];
  logic [LANES-1:0][DW-1:0] den  [QW];
  logic [LANES-1:0][QW-1:0] quo  [QW];
  logic [SW-1:0]            side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic                     v_in;
    logic [LANES-1:0][NW-1:0] r_in;
    logic [LANES-1:0][DW-1:0] d_in;
    logic [LANES-1:0][QW-1:0] q_in;
    logic [SW-1:0]            s_in;
    logic [LANES-1:0][WW-1:0] dsh;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][NW-1:0] r_next;
    logic [LANES-1:0][QW-1:0] q_next;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = in_num;
      assign d_in = in_den;
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign r_in = rem[k-1];
      assign d_in = den[k-1];
      assign q_in = quo[k-1];
      assign s_in = side[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        dsh[l]       = WW'(d_in[l]) << B;
        ge[l]        = WW'(r_in[l]) >= dsh[l];
        r_next[l]    = ge[l] ? r_in[l] - dsh[l][NW-1:0] : r_in[l];
        q_next[l]    = q_in[l];
        q_next[l][B] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
      if (en) begin
        rem[k]  <= r_next;
        den[k]  <= d_in;
        quo[k]  <= q_next;
        side[k] <= s_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

FILE: sv/bkr_locus.sv
// Planckian locus: x as a cubic in 1/T, then y as a cubic in x, by Horner steps.
// Twelve register stages, multiply and round-add alternating.
// Depends on bkr_pkg.
module bkr_locus (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [22:0]         u,
  input  bkr_pkg::side_t      in_side,
  output logic                out_valid,
  output logic signed [25:0]  x,
  output logic signed [25:0]  y,
  output bkr_pkg::side_t      out_side
);
  import bkr_pkg::*;

  logic  [11:0] vld;
  side_t        sd [12];

  logic [22:0]        u1, u2, u3, u4;
  logic signed [47:0] p1;
  logic signed [32:0] h1;
  logic signed [56:0] p2;
  logic signed [39:0] h2;
  logic signed [63:0] p3;
  logic signed [25:0] x6, x7, x8, x9, x10, x11, x12;
  logic signed [55:0] q7, q9, q11;
  logic signed [29:0] g8, g10;
  logic signed [25:0] y12;

  logic signed [24:0] a3;
  logic signed [27:0] d3;
  logic signed [47:0] p1_next;
  logic signed [32:0] h1_next;
  logic signed [56:0] p2_next;
  logic signed [39:0] h2_next;
  logic signed [63:0] p3_next;
  logic signed [25:0] x6_next;
  logic signed [55:0] q7_next, q9_next, q11_next;
  logic signed [29:0] g8_next, g10_next;
  logic signed [25:0] y12_next;

  always_comb begin
    a3       = 25'(xcoef(in_side.yb == BR_HIGH, IX_C3));
    p1_next  = 48'(a3) * 48'(signed'({1'b0, u}));
    h1_next  = 33'(shr_round(longint'(p1), 16) + xcoef(sd[0].yb == BR_HIGH, IX_C2));
    p2_next  = 57'(h1) * 57'(signed'({1'b0, u2}));
    h2_next  = 40'(shr_round(longint'(p2), 16) + xcoef(sd[2].yb == BR_HIGH, IX_C1));
    p3_next  = 64'(h2) * 64'(signed'({1'b0, u4}));
    x6_next  = 26'(shr_round(longint'(p3), 32) + xcoef(sd[4].yb == BR_HIGH, IX_C0));
    d3       = 28'(ycoef(sd[5].yb, IX_C3));
    q7_next  = 56'(d3) * 56'(x6);
    g8_next  = 30'(shr_round(longint'(q7), 24) + ycoef(sd[6].yb, IX_C2));
    q9_next  = 56'(g8) * 56'(x8);
    g10_next = 30'(shr_round(longint'(q9), 24) + ycoef(sd[8].yb, IX_C1));
    q11_next = 56'(g10) * 56'(x10);
    y12_next = 26'(shr_round(longint'(q11), 24) + ycoef(sd[10].yb, IX_C0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[10:0], in_valid};
    end
    if (en) begin
      sd[0] <= in_side;
      for (int k = 1; k < 12; k++) begin
        sd[k] <= sd[k-1];
      end
      u1  <= u;
      u2  <= u1;
      u3  <= u2;
      u4  <= u3;
      p1  <= p1_next;
      h1  <= h1_next;
      p2  <= p2_next;
      h2  <= h2_next;
      p3  <= p3_next;
      x6  <= x6_next;
      q7  <= q7_next;
      x7  <= x6;
      g8  <= g8_next;
      x8  <= x7;
      q9  <= q9_next;
      x9  <= x8;
      g10 <= g10_next;
      x10 <= x9;
      q11 <= q11_next;
      x11 <= x10;
      y12 <= y12_next;
      x12 <= x11;
    end
  end

  assign out_valid = vld[11];
  assign x         = x12;
  assign y         = y12;
  assign out_side  = sd[11];

endmodule

FILE: sv/bkr_xform.sv
// XYZ to linear sRGB: saturate X and Z, apply the matrix, clamp, find the
// largest channel and form the rounded numerators for normalization.
// Depends on bkr_pkg.
module bkr_xform (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [1:0][27:0]      quo,
  input  bkr_pkg::xside_t       in_side,
  output logic                  out_valid,
  output logic [2:0][48:0]      num,
  output logic [31:0]           den,
  output logic                  zero
);
  import bkr_pkg::*;

  logic [4:0] vld;

  logic signed [27:0] cx, cz;
  logic [15:0]        g0, g1, g2, g3;
  logic signed [54:0] pa [3];
  logic signed [54:0] pb [3];
  logic [31:0]        ch [3];
  logic [31:0]        ch3 [3];
  logic [31:0]        mx;

  logic signed [28:0] sqx, sqz;
  logic signed [27:0] cx_next, cz_next;
  logic signed [54:0] pa_next [3];
  logic signed [54:0] pb_next [3];
  logic [31:0]        ch_next [3];
  logic [31:0]        mx_next;
  logic [2:0][48:0]   num_next;
  longint             acc [3];
  longint             cr  [3];

  always_comb begin
    sqx = in_side.sx ? -signed'({1'b0, quo[0]}) : signed'({1'b0, quo[0]});
    sqz = in_side.sz ? -signed'({1'b0, quo[1]}) : signed'({1'b0, quo[1]});
    cx_next = (sqx > 29'sd134217727) ? 28'sd134217727 :
              (sqx < -29'sd134217728) ? -28'sd134217728 : 28'(sqx);
    cz_next = (sqz > 29'sd134217727) ? 28'sd134217727 :
              (sqz < -29'sd134217728) ? -28'sd134217728 : 28'(sqz);
    for (int i = 0; i < 3; i++) begin
      pa_next[i] = 55'(27'(MAT[i][0])) * 55'(cx);
      pb_next[i] = 55'(27'(MAT[i][2])) * 55'(cz);
      acc[i]     = longint'(pa[i]) + longint'(pb[i]) + (MAT[i][1] <<< 24);
      cr[i]      = shr_round(acc[i], 24);
      ch_next[i] = (cr[i] < 0) ? 32'd0 : 32'(cr[i]);
    end
    mx_next = ch[0];
    if (ch[1] > mx_next) begin
      mx_next = ch[1];
    end
    if (ch[2] > mx_next) begin
      mx_next = ch[2];
    end
    for (int i = 0; i < 3; i++) begin
      num_next[i] = 49'(ch3[i]) * 49'(g3) + 49'(mx >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
    if (en) begin
      cx <= cx_next;
      cz <= cz_next;
      g0 <= in_side.gain;
      g1 <= g0;
      g2 <= g1;
      g3 <= g2;
      for (int i = 0; i < 3; i++) begin
        pa[i]  <= pa_next[i];
        pb[i]  <= pb_next[i];
        ch[i]  <= ch_next[i];
        ch3[i] <= ch[i];
      end
      mx   <= mx_next;
      num  <= num_next;
      den  <= mx;
      zero <= (mx == 32'd0);
    end
  end

  assign out_valid = vld[4];

endmodule

FILE: sv/blackbody_kelvin_to_rgb_unit.sv
// Blackbody kelvin to linear RGB, top level.
// Throughput: one beat per cycle unless the spare output entry is full, which stalls
// the whole pipeline; the depth comes from the three restoring dividers (23, 28 and
// 16 quotient bits, one bit per stage) and 18 arithmetic stages.
// A two-entry output buffer keeps input acceptance going while one result waits.
// Reset clears the valid bits and the output buffer; there is no clearing pass.
module blackbody_kelvin_to_rgb_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] kelvin,
  input  logic [15:0] intensity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue
);
  import bkr_pkg::*;

  logic        en;
  logic        skid_v;
  logic [15:0] sk_red, sk_green, sk_blue;

  logic [15:0] t_c;
  side_t       t_side;
  logic [32:0] u_num;
  logic        u_v;
  logic [22:0] u;
  side_t       u_side;

  logic               l_v;
  logic signed [25:0] lx, ly;
  side_t              l_side;

  logic signed [25:0] yy;
  logic [25:0]        ay, ax;
  logic signed [27:0] zn;
  logic [27:0]        az;
  logic               pv;
  logic [51:0]        pnx, pnz;
  logic [25:0]        pd;
  xside_t             pside, pside_next;

  logic          xd_v;
  logic [1:0][27:0] xq;
  xside_t        xd_side;

  logic             f_in_v;
  logic [2:0][48:0] fnum;
  logic [31:0]      fden;
  logic             fzero_in;
  logic             fv;
  logic [2:0][15:0] fq;
  logic             fzero;
  logic             move;

  assign en       = !skid_v;
  assign in_ready = en;

  always_comb begin
    if (kelvin < T_MIN) begin
      t_c = T_MIN;
    end else if (kelvin > T_MAX) begin
      t_c = T_MAX;
    end else begin
      t_c = kelvin;
    end
    t_side.gain = intensity;
    if (t_c < T_SPLIT_Y) begin
      t_side.yb = BR_LOW;
    end else if (t_c < T_SPLIT_X) begin
      t_side.yb = BR_MID;
    end else begin
      t_side.yb = BR_HIGH;
    end
    u_num = 33'h1_0000_0000 + 33'(t_c >> 1);
  end

  bkr_udiv #(.NW(33), .DW(16), .QW(23), .LANES(1), .SW($bits(side_t))) u_recip (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_num(u_num), .in_den(t_c), .in_side(t_side),
    .out_valid(u_v), .out_quo(u), .out_side(u_side)
  );

  bkr_locus u_locus (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(u_v), .u(u), .in_side(u_side),
    .out_valid(l_v), .x(lx), .y(ly), .out_side(l_side)
  );

  always_comb begin
    yy = (ly >= -26'sd16 && ly <= 26'sd16) ? 26'sd17 : ly;
    ay = yy[25] ? 26'(-yy) : 26'(yy);
    ax = lx[25] ? 26'(-lx) : 26'(lx);
    zn = 28'sd16777216 - 28'(lx) - 28'(ly);
    az = zn[27] ? 28'(-zn) : 28'(zn);
    pside_next.gain = l_side.gain;
    pside_next.sx   = lx[25] ^ yy[25];
    pside_next.sz   = zn[27] ^ yy[25];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= l_v;
    end
    if (en) begin
      pnx   <= 52'({ax, 24'b0}) + 52'(ay >> 1);
      pnz   <= 52'({az, 24'b0}) + 52'(ay >> 1);
      pd    <= ay;
      pside <= pside_next;
    end
  end

  bkr_udiv #(.NW(52), .DW(26), .QW(28), .LANES(2), .SW($bits(xside_t))) u_xyz (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pv), .in_num({pnz, pnx}), .in_den({pd, pd}), .in_side(pside),
    .out_valid(xd_v), .out_quo(xq), .out_side(xd_side)
  );

  bkr_xform u_xform (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(xd_v), .quo(xq), .in_side(xd_side),
    .out_valid(f_in_v), .num(fnum), .den(fden), .zero(fzero_in)
  );

  bkr_udiv #(.NW(49), .DW(32), .QW(16), .LANES(3), .SW(1)) u_norm (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_in_v), .in_num(fnum), .in_den({fden, fden, fden}), .in_side(fzero_in),
    .out_valid(fv), .out_quo(fq), .out_side(fzero)
  );

  assign move = en && fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (move) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
        red       <= fzero ? 16'd0 : fq[0];
        green     <= fzero ? 16'd0 : fq[1];
        blue      <= fzero ? 16'd0 : fq[2];
      end else begin
        skid_v   <= 1'b1;
        sk_red   <= fzero ? 16'd0 : fq[0];
        sk_green <= fzero ? 16'd0 : fq[1];
        sk_blue  <= fzero ? 16'd0 : fq[2];
      end
    end else if (out_valid && out_ready) begin
      if (skid_v) begin
        red    <= sk_red;
        green  <= sk_green;
        blue   <= sk_blue;
        skid_v <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/bkr_checker.sv
// Port-level checks for the blackbody kelvin to RGB unit, and their binding.
// Sees only the top level's handshake and result ports.
// Depends on blackbody_kelvin_to_rgb_unit.
module bkr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] red,
  input logic [15:0] green,
  input logic [15:0] blue
);

  // Reset empties the output buffer, so nothing is shown and input is open.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output buffer not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("result beat changed while stalled");

  // With no result on display the spare entry must be empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty output");

  // Input closes only after a result went untaken.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input blocked without an output stall");

endmodule

bind blackbody_kelvin_to_rgb_unit bkr_checker u_bkr_checker (.*);

FILE: sim/tb_blackbody_kelvin_to_rgb_unit.sv
// Testbench for the blackbody kelvin to RGB unit: drives temperature and gain beats,
// predicts each RGB beat in fixed point and compares it with the output stream.
// Depends on bkr_pkg and blackbody_kelvin_to_rgb_unit.
`timescale 1ns / 1ps

module tb_blackbody_kelvin_to_rgb_unit;
  import bkr_pkg::*;

  typedef struct {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] kelvin = '0;
  logic [15:0] intensity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  rgb_t        rgb_expected[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  longint      cycle = 0;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int     LATENCY = 86;

  always #2 clk = ~clk;

  blackbody_kelvin_to_rgb_unit uut (.*);

  function automatic longint rnd_shift(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint rnd_div(longint n, longint d);
    longint unsigned an;
    longint unsigned ad;
    longint unsigned q;
    an = (n < 0) ? 64'(-n) : 64'(n);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    if (ad == 0) return 0;
    q = (an + ad / 2) / ad;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_xyz(longint v);
    if (v > 134217727) return 134217727;
    if (v < -134217728) return -134217728;
    return v;
  endfunction

  function automatic rgb_t kelvin_to_rgb(logic [15:0] k, logic [15:0] gain);
    longint t, u, h, x, y, yy, cx, cz, acc, c, maxc;
    longint ch[3];
    longint unsigned v;
    int xb, yb;
    rgb_t res;
    t = k;
    if (t < T_MIN) t = T_MIN;
    if (t > T_MAX) t = T_MAX;
    u = longint'(((64'd1 << 32) + 64'(t) / 2) / 64'(t));
    xb = (t < T_SPLIT_X) ? 0 : 1;
    h = rnd_shift(XCO[xb][IX_C3] * u, 16) + XCO[xb][IX_C2];
    h = rnd_shift(h * u, 16) + XCO[xb][IX_C1];
    x = rnd_shift(h * u, 32) + XCO[xb][IX_C0];
    yb = (t < T_SPLIT_Y) ? 0 : ((t < T_SPLIT_X) ? 1 : 2);
    h = YCO[yb][IX_C3];
    h = rnd_shift(h * x, 24) + YCO[yb][IX_C2];
    h = rnd_shift(h * x, 24) + YCO[yb][IX_C1];
    y = rnd_shift(h * x, 24) + YCO[yb][IX_C0];
    yy = (y >= -16 && y <= 16) ? 17 : y;
    cx = clamp_xyz(rnd_div(x * (64'sd1 <<< 24), yy));
    cz = clamp_xyz(rnd_div(((64'sd1 <<< 24) - x - y) * (64'sd1 <<< 24), yy));
    maxc = 0;
    for (int i = 0; i < 3; i++) begin
      acc = MAT[i][0] * cx + MAT[i][1] * (64'sd1 <<< 24) + MAT[i][2] * cz;
      c = rnd_shift(acc, 24);
      if (c < 0) c = 0;
      ch[i] = c;
      if (c > maxc) maxc = c;
    end
    for (int i = 0; i < 3; i++) begin
      v = 0;
      if (maxc > 0) begin
        v = (64'(ch[i]) * 64'(gain) + 64'(maxc) / 2) / 64'(maxc);
        if (v > 65535) v = 65535;
      end
      if (i == 0) res.r = v[15:0];
      else if (i == 1) res.g = v[15:0];
      else res.b = v[15:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("tb_blackbody_kelvin_to_rgb_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rgb_t e;
    if (!rst && out_valid && out_ready) begin
      if (rgb_expected.size() == 0) begin
        $error("red: expected none, actual %0d (unexpected beat)", red);
        errors++;
      end else begin
        e = rgb_expected.pop_front();
        if (red !== e.r) begin
          $error("red: expected %0d, actual %0d", e.r, red);
          errors++;
        end
        if (green !== e.g) begin
          $error("green: expected %0d, actual %0d", e.g, green);
          errors++;
        end
        if (blue !== e.b) begin
          $error("blue: expected %0d, actual %0d", e.b, blue);
          errors++;
        end
      end
    end
  end

  task automatic send_beat(logic [15:0] k, logic [15:0] gain);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kelvin <= k;
    intensity <= gain;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rgb_expected.push_back(kelvin_to_rgb(k, gain));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rgb_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [15:0] ks[12] = '{16'd0, 16'd999, 16'd1000, 16'd2221, 16'd2222, 16'd3999,
                           16'd4000, 16'd6500, 16'd40000, 16'd40001, 16'd65535, 16'd1500};
    logic [15:0] gs[4] = '{16'd0, 16'd4096, 16'd65535, 16'd1};
    for (int i = 0; i < 12; i++) send_beat(ks[i], gs[i % 4]);
    send_beat(16'd6500, 16'd65535);
    send_beat(16'd12345, 16'hAAAA);
    send_beat(16'd54321, 16'h5555);
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    logic [15:0] k;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: k = 16'($urandom);
        1: k = 16'($urandom_range(40000, 1000));
        2: k = 16'($urandom_range(4100, 1900));
        default: k = 16'($urandom_range(12000, 1000));
      endcase
      send_beat(k, 16'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(480, 46, 0);
    drain();
    test_random(480, 0, 46);
    test_random(480, 24, 24);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && rgb_expected.size() == 0) begin
      $display("tb_blackbody_kelvin_to_rgb_unit: done, clean");
    end else begin
      $display("tb_blackbody_kelvin_to_rgb_unit: done, errors");
    end
    $finish;
  end
endmodule
